>>> sv/char_lcd_nibble_sequencer_assert.svh
// Assertion macros for the character-LCD nibble sequencer.
// Included by the top level; needs no other file.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define LCDNS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LCDNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lcdns_pkg.sv
// Shared types, constants and the event table of the LCD nibble sequencer.
// No dependencies.
package lcdns_pkg;

   // Request codes as they arrive on the request channel
   typedef enum logic [2:0] {
      KIND_INIT   = 3'd0,
      KIND_CMD    = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SSTART = 3'd4,
      KIND_SCHAR  = 3'd5,
      KIND_SEND   = 3'd6
   } kind_type;

   localparam logic [2:0] CMD_UNDEFINED = 3'd7;

   // Configuration register indexes
   localparam logic CSR_WRAP_COLUMN = 1'b0;
   localparam logic CSR_POWER_WAIT  = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned EVENT_IDX_W = 4;

   localparam logic [7:0]  WRAP_COLUMN_RESET = 8'd7;
   localparam logic [15:0] POWER_WAIT_RESET  = 16'd15000;

   // Fixed bytes and nibbles of the controller protocol
   localparam logic [3:0] NIB_WAKE      = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
   localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
   localparam logic [7:0] BYTE_DISP_ON  = 8'h0E;
   localparam logic [7:0] BYTE_ENTRY    = 8'h06;
   localparam logic [7:0] BYTE_LINE_ONE = 8'h80;
   localparam logic [7:0] BYTE_LINE_TWO = 8'hC0;

   // Settle times in microseconds
   localparam logic [15:0] WAIT_WAKE_1   = 16'd5000;
   localparam logic [15:0] WAIT_WAKE_2   = 16'd150;
   localparam logic [15:0] WAIT_WAKE_3   = 16'd50;
   localparam logic [15:0] WAIT_FUNC_SET = 16'd140;
   localparam logic [15:0] WAIT_LONG     = 16'd5040;
   localparam logic [15:0] WAIT_CMD      = 16'd40;
   localparam logic [15:0] WAIT_DATA     = 16'd50;
   localparam logic [15:0] WAIT_ENTRY    = 16'd90;
   localparam logic [15:0] WAIT_SCHAR    = 16'd150;
   localparam logic [15:0] WAIT_LINE_TWO = 16'd140;
   localparam logic [15:0] WAIT_SEND     = 16'd150;

   // Classified request as it sits in the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       wrap;
   } job_type;

   // One bus event
   typedef struct packed {
      logic        strobe;
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] wait_us;
      logic        last;
   } event_type;

   // Configuration write bundle
   typedef struct packed {
      logic        we;
      logic        index;
      logic [15:0] wdata;
   } csr_type;

   // Back-end status for checking
   typedef struct packed {
      logic                   busy;
      logic [EVENT_IDX_W-1:0] idx;
   } back_status_type;

   // Half of a byte transfer: high nibble waits 0, low nibble carries the settle time
   function automatic event_type byte_half(logic rs, logic [7:0] value, logic high,
                                           logic [15:0] wait_us, logic last);
      event_type ev;
      ev.strobe  = 1'b1;
      ev.rs      = rs;
      ev.nibble  = high ? value[7:4] : value[3:0];
      ev.wait_us = high ? 16'd0 : wait_us;
      ev.last    = high ? 1'b0 : last;
      return ev;
   endfunction

   function automatic event_type plain_nibble(logic [3:0] nib, logic [15:0] wait_us);
      event_type ev;
      ev.strobe  = 1'b1;
      ev.rs      = 1'b0;
      ev.nibble  = nib;
      ev.wait_us = wait_us;
      ev.last    = 1'b0;
      return ev;
   endfunction

   // Event number idx of a job
   function automatic event_type event_at(job_type job, logic [EVENT_IDX_W-1:0] idx,
                                          logic [15:0] power_wait);
      event_type ev;
      ev = '{strobe: 1'b0, rs: 1'b0, nibble: 4'h0, wait_us: 16'd0, last: 1'b1};
      unique case (job.kind)
         KIND_INIT: begin
            unique case (idx)
               4'd0: ev = '{strobe: 1'b0, rs: 1'b0, nibble: 4'h0,
                            wait_us: power_wait, last: 1'b0};
               4'd1: ev = plain_nibble(NIB_WAKE, WAIT_WAKE_1);
               4'd2: ev = plain_nibble(NIB_WAKE, WAIT_WAKE_2);
               4'd3: ev = plain_nibble(NIB_WAKE, WAIT_WAKE_3);
               4'd4: ev = plain_nibble(NIB_FOUR_BIT, WAIT_WAKE_3);
               4'd5: ev = byte_half(1'b0, BYTE_FUNC_SET, 1'b1, WAIT_FUNC_SET, 1'b0);
               4'd6: ev = byte_half(1'b0, BYTE_FUNC_SET, 1'b0, WAIT_FUNC_SET, 1'b0);
               4'd7: ev = byte_half(1'b0, BYTE_DISP_ON, 1'b1, WAIT_LONG, 1'b1);
               4'd8: ev = byte_half(1'b0, BYTE_DISP_ON, 1'b0, WAIT_LONG, 1'b1);
               default: ;
            endcase
         end
         KIND_CMD:   ev = byte_half(1'b0, job.value, ~idx[0], WAIT_CMD, 1'b1);
         KIND_DATA:  ev = byte_half(1'b1, job.value, ~idx[0], WAIT_DATA, 1'b1);
         KIND_CLEAR: ev = byte_half(1'b0, BYTE_DISP_ON, ~idx[0], WAIT_LONG, 1'b1);
         KIND_SSTART: begin
            if (idx[1]) begin
               ev = byte_half(1'b0, BYTE_LINE_ONE, ~idx[0], WAIT_ENTRY, 1'b1);
            end else begin
               ev = byte_half(1'b0, BYTE_ENTRY, ~idx[0], WAIT_ENTRY, 1'b0);
            end
         end
         KIND_SCHAR: begin
            if (idx[1]) begin
               ev = byte_half(1'b0, BYTE_LINE_TWO, ~idx[0], WAIT_LINE_TWO, 1'b1);
            end else begin
               ev = byte_half(1'b1, job.value, ~idx[0], WAIT_SCHAR, ~job.wrap);
            end
         end
         KIND_SEND: ev = '{strobe: 1'b0, rs: 1'b0, nibble: 4'h0,
                           wait_us: WAIT_SEND, last: 1'b1};
         default: ;
      endcase
      return ev;
   endfunction

endpackage

>>> sv/lcdns_front.sv
// Front end: accepts requests, tracks the string position, classifies jobs.
// Depends on lcdns_pkg.
module lcdns_front (
   input  logic              clock,
   input  logic              reset,
   input  lcdns_pkg::csr_type csr,
   input  logic              accept,
   input  logic [2:0]        cmd,
   input  logic [7:0]        byte_value,
   output logic              push,
   output lcdns_pkg::job_type job,
   output logic [7:0]        string_position
);

   logic [7:0] wrap_column_ff, wrap_column_in;
   logic [7:0] position_ff, position_in;
   logic       is_schar, is_sstart;

   assign is_schar  = (cmd == lcdns_pkg::KIND_SCHAR);
   assign is_sstart = (cmd == lcdns_pkg::KIND_SSTART);

   // Classification; undefined code is dropped
   assign push       = accept && (cmd != lcdns_pkg::CMD_UNDEFINED);
   assign job.kind   = lcdns_pkg::kind_type'(cmd);
   assign job.value  = byte_value;
   assign job.wrap   = (position_ff == wrap_column_ff);

   // Position update with saturation
   always_comb begin
      position_in = position_ff;
      if (accept && is_sstart) begin
         position_in = 8'd0;
      end else if (accept && is_schar && (position_ff != 8'hFF)) begin
         position_in = position_ff + 8'd1;
      end
   end

   // Wrap column register
   always_comb begin
      wrap_column_in = wrap_column_ff;
      if (csr.we && (csr.index == lcdns_pkg::CSR_WRAP_COLUMN)) begin
         wrap_column_in = csr.wdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= 8'd0;
         wrap_column_ff <= lcdns_pkg::WRAP_COLUMN_RESET;
      end else begin
         position_ff    <= position_in;
         wrap_column_ff <= wrap_column_in;
      end
   end

   assign string_position = position_ff;

endmodule

>>> sv/lcdns_queue.sv
// Short job queue between front and back end.
// Depends on lcdns_pkg.
module lcdns_queue #(
   parameter int unsigned DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lcdns_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output lcdns_pkg::job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lcdns_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_job  = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/lcdns_back.sv
// Back end: steps through the events of the head job into the output register.
// Depends on lcdns_pkg.
module lcdns_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lcdns_pkg::csr_type        csr,
   input  logic                      job_valid,
   input  lcdns_pkg::job_type        job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lcdns_pkg::event_type      rsp_event,
   output lcdns_pkg::back_status_type status
);

   logic [15:0] power_wait_ff, power_wait_in;
   logic [lcdns_pkg::EVENT_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   lcdns_pkg::event_type  event_ff, event_in;
   logic                  fire;

   // Next event of the head job
   assign event_in = lcdns_pkg::event_at(job, idx_ff, power_wait_ff);
   assign fire     = job_valid && (!valid_ff || rsp_ready);
   assign pop      = fire && event_in.last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      if (fire) begin
         idx_in   = event_in.last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end
   end

   // Power-up wait register
   always_comb begin
      power_wait_in = power_wait_ff;
      if (csr.we && (csr.index == lcdns_pkg::CSR_POWER_WAIT)) begin
         power_wait_in = csr.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         valid_ff      <= 1'b0;
         power_wait_ff <= lcdns_pkg::POWER_WAIT_RESET;
      end else begin
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         power_wait_ff <= power_wait_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (fire) begin
         event_ff <= event_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_event   = event_ff;
   assign status.busy = job_valid;
   assign status.idx  = idx_ff;

endmodule

>>> sv/char_lcd_nibble_sequencer.sv
// Character-LCD 4-bit bus sequencer: a request is taken when the job queue has room; its
// first event passes through a queue entry and then the output register to the response side.
// The back end issues one event per cycle while a job is queued and the response side is
// ready; a request gives 1 to 9 events (init 9, string start 4, string char 2 or 4, end 1,
// others 2), and QUEUE_DEPTH jobs buffer in between. Synchronous active-high reset empties
// the queue, zeroes the string position and loads wrap column 7 and power-up wait 15000 us.
module char_lcd_nibble_sequencer #(
   parameter int unsigned QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] nibble, [19:4] wait_us, [23:20] zero
   output logic [1:0]  rsp_tuser,   // [0] strobe_res, [1] select_data
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   lcdns_pkg::csr_type         csr;
   lcdns_pkg::job_type         push_job, head_job;
   lcdns_pkg::event_type       rsp_event;
   lcdns_pkg::back_status_type back_status;
   logic       accept, push, pop, q_full, q_not_empty;
   logic [7:0] string_position;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   lcdns_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .accept          (accept),
      .cmd             (req_tuser),
      .byte_value      (req_tdata),
      .push            (push),
      .job             (push_job),
      .string_position (string_position)
   );

   lcdns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   lcdns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .job_valid (q_not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_event (rsp_event),
      .status    (back_status)
   );

   // Response packing
   assign rsp_tdata = {4'd0, rsp_event.wait_us, rsp_event.nibble};
   assign rsp_tuser = {rsp_event.rs, rsp_event.strobe};
   assign rsp_tlast = rsp_event.last;

`include "char_lcd_nibble_sequencer_assert.svh"

   `LCDNS_ASSERT_NOW(a_full_blocks_req, clock, reset, q_full, !req_tready, "ready while queue full")
   `LCDNS_ASSERT_NEXT(a_sstart_clears_pos, clock, reset,
      accept && (req_tuser == lcdns_pkg::KIND_SSTART), string_position == 8'd0,
      "string start left position nonzero")
   `LCDNS_ASSERT_NOW(a_mid_job_has_head, clock, reset, back_status.idx != '0,
      back_status.busy, "event index mid-job with empty queue")
   `LCDNS_ASSERT_NEXT(a_pop_loads_last, clock, reset, pop, rsp_tvalid && rsp_tlast,
      "job retired without last event")

endmodule

>>> tb/testbench.sv
// Self-checking bench for the character-LCD nibble sequencer: random requests and
// register writes go in, every bus event coming out is checked against a local predictor.
// Depends on lcdns_pkg and char_lcd_nibble_sequencer.
module testbench;

   // Cycles of quiet before a register write or a held-off request
   localparam int unsigned IDLE_SETTLE = 16;

   // Controller protocol values the predictor works from
   localparam logic [3:0]  WAKE_NIBBLE       = 4'h3;
   localparam logic [3:0]  FOUR_BIT_NIBBLE   = 4'h2;
   localparam logic [7:0]  FUNCTION_SET_BYTE = 8'h28;
   localparam logic [7:0]  DISPLAY_ON_BYTE   = 8'h0E;
   localparam logic [7:0]  ENTRY_MODE_BYTE   = 8'h06;
   localparam logic [7:0]  LINE_ONE_BYTE     = 8'h80;
   localparam logic [7:0]  LINE_TWO_BYTE     = 8'hC0;
   localparam logic [15:0] US_WAKE_FIRST     = 16'd5000;
   localparam logic [15:0] US_WAKE_SECOND    = 16'd150;
   localparam logic [15:0] US_WAKE_THIRD     = 16'd50;
   localparam logic [15:0] US_FUNCTION_SET   = 16'd140;
   localparam logic [15:0] US_DISPLAY_ON     = 16'd5040;
   localparam logic [15:0] US_COMMAND        = 16'd40;
   localparam logic [15:0] US_DATA           = 16'd50;
   localparam logic [15:0] US_ENTRY          = 16'd90;
   localparam logic [15:0] US_STRING_CHAR    = 16'd150;
   localparam logic [15:0] US_LINE_TWO       = 16'd140;
   localparam logic [15:0] US_STRING_END     = 16'd150;

   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_CSR_WRITE,
      OP_DRAIN
   } plan_op_type;

   typedef struct {
      plan_op_type op;
      logic [2:0]  cmd;
      logic [7:0]  value;
      logic        index;
      logic [15:0] wdata;
      bit          calm;
   } plan_entry_type;

   typedef struct {
      logic        strobe;
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] wait_us;
      logic        last;
   } lcd_event_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] byte_value
   logic [2:0]  req_tuser  = '0;   // [2:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [3:0] nibble, [19:4] wait_us, [23:20] zero
   logic [1:0]  rsp_tuser;         // [0] strobe_res, [1] select_data
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = '0;

   plan_entry_type request_plan[$];
   lcd_event_type  lcd_events_due[$];
   int unsigned err_count = 0;
   bit          plan_calm = 1'b0;
   bit          idle_calm = 1'b0;

   // Predictor state and its copy of the registers
   logic [7:0]  cfg_wrap_column = 8'd7;
   logic [15:0] cfg_power_wait  = 16'd15000;
   logic [7:0]  str_position    = 8'd0;

   char_lcd_nibble_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_pause();
      return idle_calm ? 0 : $urandom_range(0, 17);
   endfunction

   // ---------------- predictor ----------------
   function automatic void add_event(logic strobe, logic rs, logic [3:0] nib,
                                     logic [15:0] wait_us);
      lcd_event_type ev;
      ev.strobe  = strobe;
      ev.rs      = rs;
      ev.nibble  = nib;
      ev.wait_us = wait_us;
      ev.last    = 1'b0;
      lcd_events_due.push_back(ev);
   endfunction

   // High nibble first with no wait, the low nibble carries the settle time
   function automatic void add_byte(logic rs, logic [7:0] value, logic [15:0] wait_us);
      add_event(1'b1, rs, value[7:4], 16'd0);
      add_event(1'b1, rs, value[3:0], wait_us);
   endfunction

   function automatic void sequence_request(logic [2:0] cmd, logic [7:0] value);
      int unsigned   before_n;
      lcd_event_type tail;
      before_n = lcd_events_due.size();
      case (cmd)
         lcdns_pkg::KIND_INIT: begin
            add_event(1'b0, 1'b0, 4'h0, cfg_power_wait);
            add_event(1'b1, 1'b0, WAKE_NIBBLE, US_WAKE_FIRST);
            add_event(1'b1, 1'b0, WAKE_NIBBLE, US_WAKE_SECOND);
            add_event(1'b1, 1'b0, WAKE_NIBBLE, US_WAKE_THIRD);
            add_event(1'b1, 1'b0, FOUR_BIT_NIBBLE, US_WAKE_THIRD);
            add_byte(1'b0, FUNCTION_SET_BYTE, US_FUNCTION_SET);
            add_byte(1'b0, DISPLAY_ON_BYTE, US_DISPLAY_ON);
         end
         lcdns_pkg::KIND_CMD:   add_byte(1'b0, value, US_COMMAND);
         lcdns_pkg::KIND_DATA:  add_byte(1'b1, value, US_DATA);
         lcdns_pkg::KIND_CLEAR: add_byte(1'b0, DISPLAY_ON_BYTE, US_DISPLAY_ON);
         lcdns_pkg::KIND_SSTART: begin
            add_byte(1'b0, ENTRY_MODE_BYTE, US_ENTRY);
            add_byte(1'b0, LINE_ONE_BYTE, US_ENTRY);
            str_position = 8'd0;
         end
         lcdns_pkg::KIND_SCHAR: begin
            add_byte(1'b1, value, US_STRING_CHAR);
            if (str_position == cfg_wrap_column) begin
               add_byte(1'b0, LINE_TWO_BYTE, US_LINE_TWO);
            end
            // position saturates at the top
            if (str_position != 8'hFF) begin
               str_position = str_position + 8'd1;
            end
         end
         lcdns_pkg::KIND_SEND:  add_event(1'b0, 1'b0, 4'h0, US_STRING_END);
         default: ;
      endcase
      if (lcd_events_due.size() > before_n) begin
         tail = lcd_events_due.pop_back();
         tail.last = 1'b1;
         lcd_events_due.push_back(tail);
      end
   endfunction

   // ---------------- request driver ----------------
   always @(posedge clock) begin : request_driver
      logic           next_valid;
      logic           next_we;
      plan_entry_type head;
      logic [2:0]     cur_cmd;
      logic [7:0]     cur_value;
      int unsigned    send_gap;
      int unsigned    quiet;
      next_valid = req_tvalid;
      next_we    = 1'b0;
      if (reset) begin
         next_valid = 1'b0;
         send_gap   = 0;
         quiet      = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sequence_request(cur_cmd, cur_value);
            next_valid = 1'b0;
            send_gap   = draw_pause();
         end
         if (!next_valid && request_plan.size() > 0) begin
            head = request_plan[0];
            if (head.op == OP_REQUEST) begin
               quiet = 0;
               if (send_gap > 0) begin
                  send_gap = send_gap - 1;
               end else begin
                  cur_cmd   = head.cmd;
                  cur_value = head.value;
                  idle_calm = head.calm;
                  req_tuser  <= head.cmd;
                  req_tdata  <= head.value;
                  next_valid = 1'b1;
                  head = request_plan.pop_front();
               end
            end else if (lcd_events_due.size() != 0) begin
               quiet = 0;
            end else if (quiet < IDLE_SETTLE) begin
               quiet = quiet + 1;
            end else begin
               // block is idle: register write or end of a hold-off
               if (head.op == OP_CSR_WRITE) begin
                  csr_index <= head.index;
                  csr_wdata <= head.wdata;
                  next_we = 1'b1;
                  if (head.index == lcdns_pkg::CSR_WRAP_COLUMN) begin
                     cfg_wrap_column = head.wdata[7:0];
                  end else begin
                     cfg_power_wait = head.wdata;
                  end
               end
               quiet = 0;
               head = request_plan.pop_front();
            end
         end
      end
      req_tvalid <= next_valid;
      csr_we     <= next_we;
   end

   // ---------------- event monitor ----------------
   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : event_monitor
      logic          next_ready;
      lcd_event_type want;
      int unsigned   recv_stall;
      next_ready = rsp_tready;
      if (reset) begin
         next_ready = 1'b0;
         recv_stall = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (lcd_events_due.size() == 0) begin
            $error("unexpected event: strobe %0d nibble %0d wait_us %0d",
                   rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[19:4]);
            err_count++;
         end else begin
            want = lcd_events_due.pop_front();
            check_field("strobe_res", 16'(want.strobe), 16'(rsp_tuser[0]));
            check_field("select_data", 16'(want.rs), 16'(rsp_tuser[1]));
            check_field("nibble", 16'(want.nibble), 16'(rsp_tdata[3:0]));
            check_field("wait_us", want.wait_us, rsp_tdata[19:4]);
            check_field("last", 16'(want.last), 16'(rsp_tlast));
         end
         recv_stall = draw_pause();
         next_ready = (recv_stall == 0);
      end else if (!rsp_tready) begin
         if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_tready <= next_ready;
   end

   // ---------------- stimulus plan ----------------
   task automatic plan_request(logic [2:0] cmd, logic [7:0] value);
      plan_entry_type e;
      e.op    = OP_REQUEST;
      e.cmd   = cmd;
      e.value = value;
      e.index = 1'b0;
      e.wdata = '0;
      e.calm  = plan_calm;
      request_plan.push_back(e);
   endtask

   task automatic plan_csr(logic index, logic [15:0] wdata);
      plan_entry_type e;
      e.op    = OP_CSR_WRITE;
      e.cmd   = '0;
      e.value = '0;
      e.index = index;
      e.wdata = wdata;
      e.calm  = plan_calm;
      request_plan.push_back(e);
   endtask

   task automatic plan_drain();
      plan_entry_type e;
      e.op    = OP_DRAIN;
      e.cmd   = '0;
      e.value = '0;
      e.index = 1'b0;
      e.wdata = '0;
      e.calm  = plan_calm;
      request_plan.push_back(e);
   endtask

   // Mostly string runs with random text; some lack their start or end
   task automatic plan_random_traffic(int unsigned count, bit flip_calm);
      int unsigned made;
      int unsigned chars;
      int unsigned pick;
      logic [2:0]  cmd;
      made = 0;
      while (made < count) begin
         if (flip_calm && $urandom_range(0, 7) == 0) begin
            plan_calm = !plan_calm;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) != 0) begin
               plan_request(lcdns_pkg::KIND_SSTART, 8'($urandom_range(0, 255)));
               made++;
            end
            chars = $urandom_range(0, 20);
            repeat (chars) plan_request(lcdns_pkg::KIND_SCHAR, 8'($urandom_range(0, 255)));
            made += chars;
            if ($urandom_range(0, 9) != 0) begin
               plan_request(lcdns_pkg::KIND_SEND, 8'($urandom_range(0, 255)));
               made++;
            end
         end else if (pick < 95) begin
            cmd = 3'($urandom_range(0, 7));
            plan_request(cmd, 8'($urandom_range(0, 255)));
            if (cmd != lcdns_pkg::CMD_UNDEFINED) begin
               made++;
            end
         end else begin
            plan_drain();
         end
      end
   endtask

   initial begin
      // directed part under reset register values
      plan_calm = 1'b0;
      plan_request(lcdns_pkg::KIND_INIT, 8'hFF);
      plan_request(lcdns_pkg::KIND_CMD, 8'h00);
      plan_request(lcdns_pkg::KIND_CMD, 8'hFF);
      plan_request(lcdns_pkg::KIND_DATA, 8'hA5);
      plan_request(lcdns_pkg::KIND_DATA, 8'h5A);
      plan_request(lcdns_pkg::KIND_CLEAR, 8'hFF);
      plan_request(lcdns_pkg::KIND_SSTART, 8'h3C);
      // nine characters, the eighth crosses to line two
      for (int i = 0; i < 9; i++) begin
         plan_request(lcdns_pkg::KIND_SCHAR, 8'(8'h41 + i));
      end
      plan_request(lcdns_pkg::KIND_SEND, 8'hFF);
      plan_request(lcdns_pkg::CMD_UNDEFINED, 8'hFF);
      plan_request(lcdns_pkg::CMD_UNDEFINED, 8'h00);
      // character with no string start keeps counting
      plan_request(lcdns_pkg::KIND_SCHAR, 8'h7E);
      plan_request(lcdns_pkg::KIND_CMD, 8'h0F);
      plan_request(lcdns_pkg::KIND_SEND, 8'h00);
      plan_drain();

      plan_csr(lcdns_pkg::CSR_WRAP_COLUMN, 16'($urandom_range(1, 12)));
      plan_csr(lcdns_pkg::CSR_POWER_WAIT, 16'($urandom_range(0, 65535)));
      plan_random_traffic(50, 1'b0);

      // lowest register values, no idling
      plan_calm = 1'b1;
      plan_csr(lcdns_pkg::CSR_WRAP_COLUMN, 16'd0);
      plan_csr(lcdns_pkg::CSR_POWER_WAIT, 16'd0);
      plan_request(lcdns_pkg::KIND_INIT, 8'h00);
      plan_random_traffic(35, 1'b0);

      // highest register values
      plan_csr(lcdns_pkg::CSR_WRAP_COLUMN, 16'd255);
      plan_csr(lcdns_pkg::CSR_POWER_WAIT, 16'hFFFF);
      plan_request(lcdns_pkg::KIND_INIT, 8'h00);
      plan_request(lcdns_pkg::KIND_SSTART, 8'h00);
      repeat (6) plan_request(lcdns_pkg::KIND_SCHAR, 8'($urandom_range(0, 255)));
      plan_request(lcdns_pkg::KIND_SEND, 8'h00);

      plan_calm = 1'b0;
      plan_csr(lcdns_pkg::CSR_WRAP_COLUMN, 16'($urandom_range(0, 20)));
      plan_csr(lcdns_pkg::CSR_POWER_WAIT, 16'($urandom_range(0, 65535)));
      plan_random_traffic(55, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_plan.size() != 0 || req_tvalid || lcd_events_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (IDLE_SETTLE) @(posedge clock);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
